// ----- sv/lpfd_pkg.sv -----
// Shared types, codes and constants of the length-prefixed frame deframer.
`timescale 1ns / 1ps

package lpfd_pkg;

  localparam int unsigned HEADER_SIZE   = 8;
  localparam int unsigned CFG_INDEX_W   = 8;
  localparam int unsigned CFG_DATA_W    = 32;

  localparam logic [7:0]  MAGIC_RESET      = 8'd88;
  localparam logic [31:0] MAX_LENGTH_RESET = 32'd10485760;
  localparam logic [31:0] HEADER_LEN       = 32'd8;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_BAD_MAGIC  = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG   = 2'd1;
  localparam logic [1:0] ERR_TOO_SHORT  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_VALUE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH  = 8'd1;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_BODY   = 3'b010,
    PH_ERROR  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0]  magic_value;
    logic [31:0] max_length;
  } lpfd_cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  version;
    logic [15:0] service;
    logic [31:0] total_length;
    logic [7:0]  body_byte;
    logic        last_of_message;
    logic [1:0]  error_code;
  } lpfd_res_t;

endpackage

// ----- sv/lpfd_if.sv -----
// Channel interfaces: byte stream, result stream and configuration writes.
`timescale 1ns / 1ps

interface lpfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lpfd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  version;
  logic [15:0] service;
  logic [31:0] total_length;
  logic [7:0]  body_byte;
  logic        last_of_message;
  logic [1:0]  error_code;

  modport source (output valid, output kind, output version, output service,
                  output total_length, output body_byte, output last_of_message,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input version, input service,
                  input total_length, input body_byte, input last_of_message,
                  input error_code, output ready);
endinterface

interface lpfd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lpfd_pkg::CFG_INDEX_W-1:0]    index;
  logic [lpfd_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/lpfd_parser.sv -----
// Frame parser: header gathering, header checks, body countdown, error hold.
`timescale 1ns / 1ps

module lpfd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  lpfd_pkg::lpfd_cfg_t cfg,
  output logic                res_valid,
  output lpfd_pkg::lpfd_res_t res
);

  lpfd_pkg::phase_t phase, phase_next;
  logic [2:0]       header_count, header_count_next;
  logic [55:0]      header_bytes, header_bytes_next;
  logic [31:0]      body_remaining, body_remaining_next;

  logic [63:0]      hdr_word;
  logic [7:0]       hdr_version;
  logic [7:0]       hdr_magic;
  logic [15:0]      hdr_service;
  logic [31:0]      hdr_length;

  assign hdr_word    = {header_bytes, in_byte};
  assign hdr_version = hdr_word[63:56];
  assign hdr_magic   = hdr_word[55:48];
  assign hdr_service = hdr_word[47:32];
  assign hdr_length  = hdr_word[31:0];

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    header_bytes_next   = header_bytes;
    body_remaining_next = body_remaining;
    res_valid           = 1'b0;
    res                 = '0;
    case (phase)
      lpfd_pkg::PH_HEADER: begin
        if (accept) begin
          header_bytes_next = hdr_word[55:0];
          if (header_count != 3'd7) begin
            header_count_next = header_count + 3'd1;
          end else begin
            header_count_next = 3'd0;
            res_valid         = 1'b1;
            // Check order: magic, then upper bound, then lower bound.
            if (hdr_magic != cfg.magic_value) begin
              res.kind       = lpfd_pkg::KIND_ERROR;
              res.error_code = lpfd_pkg::ERR_BAD_MAGIC;
              phase_next     = lpfd_pkg::PH_ERROR;
            end else if (hdr_length > cfg.max_length) begin
              res.kind       = lpfd_pkg::KIND_ERROR;
              res.error_code = lpfd_pkg::ERR_TOO_LONG;
              phase_next     = lpfd_pkg::PH_ERROR;
            end else if (hdr_length < lpfd_pkg::HEADER_LEN) begin
              res.kind       = lpfd_pkg::KIND_ERROR;
              res.error_code = lpfd_pkg::ERR_TOO_SHORT;
              phase_next     = lpfd_pkg::PH_ERROR;
            end else begin
              res.kind         = lpfd_pkg::KIND_HEADER;
              res.version      = hdr_version;
              res.service      = hdr_service;
              res.total_length = hdr_length;
              if (hdr_length == lpfd_pkg::HEADER_LEN) begin
                // header-only frame: stay in header phase
                res.last_of_message = 1'b1;
              end else begin
                body_remaining_next = hdr_length - lpfd_pkg::HEADER_LEN;
                phase_next          = lpfd_pkg::PH_BODY;
              end
            end
          end
        end
      end
      lpfd_pkg::PH_BODY: begin
        if (accept) begin
          res_valid           = 1'b1;
          res.kind            = lpfd_pkg::KIND_BODY;
          res.body_byte       = in_byte;
          body_remaining_next = body_remaining - 32'd1;
          if (body_remaining == 32'd1) begin
            res.last_of_message = 1'b1;
            phase_next          = lpfd_pkg::PH_HEADER;
            header_count_next   = 3'd0;
          end
        end
      end
      default: begin
        // error hold: drop every byte
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= lpfd_pkg::PH_HEADER;
      header_count   <= 3'd0;
      header_bytes   <= '0;
      body_remaining <= '0;
    end else begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      header_bytes   <= header_bytes_next;
      body_remaining <= body_remaining_next;
    end
  end

  a_error_holds: assert property (@(posedge clk) disable iff (rst)
    phase == lpfd_pkg::PH_ERROR |=> phase == lpfd_pkg::PH_ERROR)
    else $error("error phase left before reset");

  a_partial_header_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == lpfd_pkg::PH_HEADER && header_count != 3'd7) |-> !res_valid)
    else $error("result produced before eighth header byte");

  a_error_enters_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == lpfd_pkg::KIND_ERROR) |=> phase == lpfd_pkg::PH_ERROR)
    else $error("error result without entering error phase");

  a_body_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == lpfd_pkg::PH_BODY |-> body_remaining != 32'd0)
    else $error("body phase with no bytes remaining");

endmodule

// ----- sv/length_prefixed_frame_deframer.sv -----
// Top level of the length-prefixed frame deframer: config registers and result register.
//
//   channel  role    payload                                          handshake
//   stream   sink    in_byte                                          valid/ready
//   result   source  kind version service total_length body_byte     valid/ready
//                    last_of_message error_code
//   cfg      sink    index data                                       valid/ready
//
// One byte per cycle: a byte is accepted whenever the result register is empty
// or its transaction completes in the same cycle; the result is registered and
// appears in the cycle after the byte that causes it. The header check is an 8-bit magic
// compare and a 32-bit length compare pair, header shift register to result register.
// Synchronous reset restores magic_value 88, max_length 10485760, header phase.
// A stall on result holds the result register and stops stream intake.
`timescale 1ns / 1ps

module length_prefixed_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  lpfd_byte_if.sink   stream,
  lpfd_res_if.source  result,
  lpfd_cfg_if.sink    cfg
);

  lpfd_pkg::lpfd_cfg_t cfg_regs;
  lpfd_pkg::lpfd_res_t res_comb;
  lpfd_pkg::lpfd_res_t out_reg;
  logic                res_valid;
  logic                out_valid;
  logic                accept;

  assign cfg.ready    = 1'b1;
  assign stream.ready = !out_valid || result.ready;
  assign accept       = stream.valid && stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.magic_value <= lpfd_pkg::MAGIC_RESET;
      cfg_regs.max_length  <= lpfd_pkg::MAX_LENGTH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        lpfd_pkg::REG_MAGIC_VALUE: cfg_regs.magic_value <= cfg.data[7:0];
        lpfd_pkg::REG_MAX_LENGTH:  cfg_regs.max_length  <= cfg.data[31:0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  lpfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (stream.in_byte),
    .cfg       (cfg_regs),
    .res_valid (res_valid),
    .res       (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_reg <= res_comb;
    end
  end

  assign result.valid           = out_valid;
  assign result.kind            = out_reg.kind;
  assign result.version         = out_reg.version;
  assign result.service         = out_reg.service;
  assign result.total_length    = out_reg.total_length;
  assign result.body_byte       = out_reg.body_byte;
  assign result.last_of_message = out_reg.last_of_message;
  assign result.error_code      = out_reg.error_code;

endmodule
